FILE: rtl/core/spi_nor_flash_command_sequencer_defines.svh
// ----------------------------------------------------------------------------
// SPI NOR command sequencer assertion macros
// Shared assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// checked outside reset only
`define SPINOR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spinor assertion failed");

// checked on every edge, reset included
`define SPINOR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spinor assertion failed");

`endif

FILE: rtl/core/spinor_pkg.sv
// ----------------------------------------------------------------------------
// spinor_pkg
// Types, codes and the word generator shared by the sequencer modules.
// ----------------------------------------------------------------------------
package spinor_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int ADDR_BITS_DEF    = 24;
  localparam int QUEUE_DEPTH      = 4;
  localparam logic [15:0] POLL_LIMIT_RST = 16'd500;

  // input commands
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_ERASE  = 3'd2;
  localparam logic [2:0] CMD_DATA   = 3'd3;
  localparam logic [2:0] CMD_STATUS = 3'd4;

  // result status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_TIMEOUT    = 3'd3;
  localparam logic [2:0] ST_UNEXPECTED = 3'd4;

  // flash opcodes
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_PROG  = 8'h02;
  localparam logic [7:0] OPC_ERASE = 8'h20;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_DUMMY = 8'hff;

  // word sequences queued between front and back
  localparam logic [2:0] JOB_READ      = 3'd0;
  localparam logic [2:0] JOB_PAGE      = 3'd1;
  localparam logic [2:0] JOB_DATA      = 3'd2;
  localparam logic [2:0] JOB_DATA_POLL = 3'd3;
  localparam logic [2:0] JOB_POLL      = 3'd4;
  localparam logic [2:0] JOB_ERASE     = 3'd5;
  localparam logic [2:0] JOB_STATUS    = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [7:0]  data_byte;
    logic [2:0]  status;
  } job_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       byte_valid;
    logic       await_status;
    logic [2:0] status;
    logic       last;
  } word_t;

  function automatic word_t mk_word(logic [7:0] b, logic aw, logic [2:0] st, logic lst);
    word_t w;
    w.spi_byte     = b;
    w.byte_valid   = 1'b1;
    w.await_status = aw;
    w.status       = st;
    w.last         = lst;
    return w;
  endfunction

  function automatic word_t job_word(job_t j, logic [2:0] step);
    word_t w;
    w = mk_word(8'h00, 1'b0, ST_BUSY, 1'b1);
    unique case (j.kind)
      JOB_READ: begin
        unique case (step)
          3'd0:    w = mk_word(OPC_READ, 1'b0, ST_BUSY, 1'b0);
          3'd1:    w = mk_word(j.addr[23:16], 1'b0, ST_BUSY, 1'b0);
          3'd2:    w = mk_word(j.addr[15:8], 1'b0, ST_BUSY, 1'b0);
          default: w = mk_word(j.addr[7:0], 1'b0, ST_DONE, 1'b1);
        endcase
      end
      JOB_PAGE: begin
        unique case (step)
          3'd0:    w = mk_word(OPC_WREN, 1'b0, ST_BUSY, 1'b0);
          3'd1:    w = mk_word(OPC_PROG, 1'b0, ST_BUSY, 1'b0);
          3'd2:    w = mk_word(j.addr[23:16], 1'b0, ST_BUSY, 1'b0);
          3'd3:    w = mk_word(j.addr[15:8], 1'b0, ST_BUSY, 1'b0);
          default: w = mk_word(j.addr[7:0], 1'b0, ST_BUSY, 1'b1);
        endcase
      end
      JOB_DATA: w = mk_word(j.data_byte, 1'b0, ST_BUSY, 1'b1);
      JOB_DATA_POLL: begin
        unique case (step)
          3'd0:    w = mk_word(j.data_byte, 1'b0, ST_BUSY, 1'b0);
          3'd1:    w = mk_word(OPC_RDSR, 1'b0, ST_BUSY, 1'b0);
          default: w = mk_word(OPC_DUMMY, 1'b1, ST_BUSY, 1'b1);
        endcase
      end
      JOB_POLL: begin
        unique case (step)
          3'd0:    w = mk_word(OPC_RDSR, 1'b0, ST_BUSY, 1'b0);
          default: w = mk_word(OPC_DUMMY, 1'b1, ST_BUSY, 1'b1);
        endcase
      end
      JOB_ERASE: begin
        unique case (step)
          3'd0:    w = mk_word(OPC_WREN, 1'b0, ST_BUSY, 1'b0);
          3'd1:    w = mk_word(OPC_ERASE, 1'b0, ST_BUSY, 1'b0);
          3'd2:    w = mk_word(j.addr[23:16], 1'b0, ST_BUSY, 1'b0);
          3'd3:    w = mk_word(j.addr[15:8], 1'b0, ST_BUSY, 1'b0);
          3'd4:    w = mk_word(j.addr[7:0], 1'b0, ST_BUSY, 1'b0);
          3'd5:    w = mk_word(OPC_RDSR, 1'b0, ST_BUSY, 1'b0);
          default: w = mk_word(OPC_DUMMY, 1'b1, ST_BUSY, 1'b1);
        endcase
      end
      default: begin
        w.spi_byte     = 8'h00;
        w.byte_valid   = 1'b0;
        w.await_status = 1'b0;
        w.status       = j.status;
        w.last         = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/spinor_queue.sv
// ----------------------------------------------------------------------------
// spinor_queue
// Small job queue between the classifier and the word generator.
// ----------------------------------------------------------------------------
module spinor_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spinor_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output spinor_pkg::job_t  head
);
  import spinor_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/spinor_front.sv
// ----------------------------------------------------------------------------
// spinor_front
// Accepts input words, tracks the flash operation and queues word jobs.
// ----------------------------------------------------------------------------
module spinor_front #(
  parameter int PAGE_BYTES   = spinor_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = spinor_pkg::SECTOR_BYTES_DEF,
  parameter int ADDR_BITS    = spinor_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        command,
  input  logic [23:0]       address,
  input  logic [23:0]       length,
  input  logic [7:0]        data_byte,
  output logic              push,
  output spinor_pkg::job_t  push_job,
  input  logic              full
);
  import spinor_pkg::*;

  // page and sector sizes are powers of two
  localparam int PAGE_W = $clog2(PAGE_BYTES) + 1;
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
  localparam logic [31:0] SEC_MASK  = 32'(SECTOR_BYTES - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_POLL = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  logic [15:0]          poll_limit;
  logic [1:0]           phase, phase_next;
  logic [1:0]           operation, operation_next;
  logic [ADDR_BITS-1:0] cur_addr, cur_addr_next;
  logic [23:0]          remaining, remaining_next;
  logic [PAGE_W-1:0]    page_left, page_left_next;
  logic [15:0]          polls_left, polls_left_next;

  logic [ADDR_BITS-1:0] addr_m;
  logic [31:0]          addr_w;
  logic [PAGE_W-1:0]    room;
  logic [15:0]          limit_eff;
  logic [15:0]          polls_dec;
  logic [23:0]          rem_sec;
  logic [ADDR_BITS-1:0] next_sector;
  job_t                 job;

  assign in_ready = !full && !rst;
  assign push     = in_valid && in_ready;
  assign push_job = job;

  assign addr_m      = ADDR_BITS'(address);
  assign addr_w      = 32'(addr_m);
  assign room        = PAGE_W'(PAGE_BYTES) - PAGE_W'(addr_w & PAGE_MASK);
  assign limit_eff   = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
  assign polls_dec   = (polls_left == 16'd0) ? 16'd0 : polls_left - 16'd1;
  assign rem_sec     = (32'(remaining) >= 32'(SECTOR_BYTES)) ?
                       24'(32'(remaining) - 32'(SECTOR_BYTES)) : 24'd0;
  assign next_sector = cur_addr + ADDR_BITS'(SECTOR_BYTES);

  always_comb begin
    phase_next      = phase;
    operation_next  = operation;
    cur_addr_next   = cur_addr;
    remaining_next  = remaining;
    page_left_next  = page_left;
    polls_left_next = polls_left;
    job.kind        = JOB_STATUS;
    job.addr        = 24'(cur_addr);
    job.data_byte   = data_byte;
    job.status      = ST_UNEXPECTED;
    priority if (phase == PH_IDLE && command == CMD_READ) begin
      job.kind = JOB_READ;
      job.addr = 24'(addr_m);
    end else if (phase == PH_IDLE && command == CMD_WRITE) begin
      if (length == 24'd0) begin
        job.status     = ST_DONE;
        operation_next = OP_NONE;
      end else begin
        job.kind       = JOB_PAGE;
        job.addr       = 24'(addr_m);
        operation_next = OP_WRITE;
        cur_addr_next  = addr_m;
        remaining_next = length;
        page_left_next = (length < 24'(room)) ? length[PAGE_W-1:0] : room;
        phase_next     = PH_DATA;
      end
    end else if (phase == PH_IDLE && command == CMD_ERASE) begin
      if ((addr_w & SEC_MASK) != 32'd0 || (32'(length) & SEC_MASK) != 32'd0) begin
        job.status     = ST_MISALIGNED;
        operation_next = OP_NONE;
      end else if (length == 24'd0) begin
        job.status     = ST_DONE;
        operation_next = OP_NONE;
      end else begin
        job.kind        = JOB_ERASE;
        job.addr        = 24'(addr_m);
        operation_next  = OP_ERASE;
        cur_addr_next   = addr_m;
        remaining_next  = length;
        polls_left_next = limit_eff;
        phase_next      = PH_POLL;
      end
    end else if (phase == PH_DATA && command == CMD_DATA) begin
      page_left_next = page_left - 1'b1;
      remaining_next = remaining - 24'd1;
      cur_addr_next  = cur_addr + 1'b1;
      if (page_left == PAGE_W'(1)) begin
        job.kind        = JOB_DATA_POLL;
        polls_left_next = limit_eff;
        phase_next      = PH_POLL;
      end else begin
        job.kind = JOB_DATA;
      end
    end else if (phase == PH_POLL && command == CMD_STATUS) begin
      if (data_byte[0]) begin
        polls_left_next = polls_dec;
        if (polls_dec == 16'd0) begin
          job.status     = ST_TIMEOUT;
          phase_next     = PH_IDLE;
          operation_next = OP_NONE;
        end else begin
          job.kind = JOB_POLL;
        end
      end else if (operation == OP_WRITE && remaining != 24'd0) begin
        job.kind       = JOB_PAGE;
        page_left_next = (32'(remaining) < 32'(PAGE_BYTES)) ?
                         remaining[PAGE_W-1:0] : PAGE_W'(PAGE_BYTES);
        phase_next     = PH_DATA;
      end else if (operation == OP_ERASE && rem_sec != 24'd0) begin
        job.kind        = JOB_ERASE;
        job.addr        = 24'(next_sector);
        cur_addr_next   = next_sector;
        remaining_next  = rem_sec;
        polls_left_next = limit_eff;
      end else begin
        if (operation == OP_ERASE) begin
          cur_addr_next  = next_sector;
          remaining_next = rem_sec;
        end
        job.status     = ST_DONE;
        phase_next     = PH_IDLE;
        operation_next = OP_NONE;
      end
    end else begin
      job.status = ST_UNEXPECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RST;
      phase      <= PH_IDLE;
      operation  <= OP_NONE;
      cur_addr   <= '0;
      remaining  <= '0;
      page_left  <= '0;
      polls_left <= '0;
    end else begin
      if (cfg_we) poll_limit <= cfg_wdata;
      if (push) begin
        phase      <= phase_next;
        operation  <= operation_next;
        cur_addr   <= cur_addr_next;
        remaining  <= remaining_next;
        page_left  <= page_left_next;
        polls_left <= polls_left_next;
      end
    end
  end

endmodule

FILE: rtl/core/spinor_back.sv
// ----------------------------------------------------------------------------
// spinor_back
// Expands queued jobs into SPI words, one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module spinor_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  spinor_pkg::job_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output spinor_pkg::word_t out_word
);
  import spinor_pkg::*;

  logic       busy;
  job_t       job;
  logic [2:0] step;
  logic       take;

  assign out_valid = busy;
  assign out_word  = job_word(job, step);
  assign take      = !busy || (out_ready && out_word.last);
  assign pop       = take && !empty;

  always_ff @(posedge clk) begin
    if (pop) job <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (take) begin
      busy <= !empty;
      step <= '0;
    end else if (out_ready) begin
      step <= step + 1'b1;
    end
  end

endmodule

FILE: rtl/core/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Turns read, write and erase requests into SPI byte words for a NOR flash.
// ----------------------------------------------------------------------------
// Each input word is classified combinationally and leaves a job in a four-entry
// queue; the word generator then emits that job's 1 to 7 output words, one per
// clock while m_axis_tready is high. An input word is taken every cycle while
// the queue has room, so sustained throughput is set by the number of output
// words per input (1 for a data byte, 3 for the data byte that closes a page,
// 4 for a read, up to 7 for an erase). s_axis_tready is low during reset.
// command travels on s_axis_tuser; the final word of each input carries tlast.
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES   = spinor_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = spinor_pkg::SECTOR_BYTES_DEF,
  parameter int ADDR_BITS    = spinor_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // poll_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // address[23:0], length[47:24], data_byte[55:48]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // spi_byte[7:0], byte_valid[8], await_status[9],
                                     // status[12:10], zero[15:13]
  output logic        m_axis_tlast
);
  import spinor_pkg::*;

  logic  push, full, pop, empty;
  job_t  push_job, head;
  word_t word;

  spinor_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .command   (s_axis_tuser),
    .address   (s_axis_tdata[23:0]),
    .length    (s_axis_tdata[47:24]),
    .data_byte (s_axis_tdata[55:48]),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  spinor_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  spinor_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (word)
  );

  assign m_axis_tdata = {3'b000, word.status, word.await_status, word.byte_valid,
                         word.spi_byte};
  assign m_axis_tlast = word.last;

endmodule

FILE: rtl/core/spinor_checker.sv
// ----------------------------------------------------------------------------
// spinor_checker
// Port-level checks on the sequencer output stream.
// ----------------------------------------------------------------------------
`include "spi_nor_flash_command_sequencer_defines.svh"

module spinor_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `SPINOR_ASSERT_ALWAYS(a_idle_after_rst, rst |=> !m_axis_tvalid)

  `SPINOR_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  `SPINOR_ASSERT(a_status_word, m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00 && m_axis_tlast)

  `SPINOR_ASSERT(a_poll_dummy, m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'hff && m_axis_tdata[8] && m_axis_tlast)

  `SPINOR_ASSERT(a_status_last, m_axis_tvalid && m_axis_tdata[12:10] != 3'd0 |-> m_axis_tlast)

endmodule

bind spi_nor_flash_command_sequencer spinor_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
